// ===== hw/rtl/nnt_pkg.sv =====
package nnt_pkg;

  // configuration register widths
  localparam int CFG_W      = 12;
  localparam int LOST_W     = 8;
  localparam int CFG_IDX_W  = 3;

  // saturation value of the lost frame counter
  localparam logic [LOST_W-1:0] LOST_SAT = '1;

  // input item kinds
  typedef enum logic [1:0] {
    CMD_DET     = 2'd0,
    CMD_DET_END = 2'd1,
    CMD_END     = 2'd2,
    CMD_NONE    = 2'd3
  } nnt_cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_MAX_JUMP_X = 3'd2,
    REG_MAX_JUMP_Y = 3'd3,
    REG_MAX_LOST   = 3'd4
  } nnt_reg_t;

  // per-cycle control from the input stage
  typedef struct packed {
    logic take;   // item carries a detection
    logic fin;    // item ends the frame
  } nnt_ctl_t;

endpackage

// ===== hw/rtl/nnt_search.sv =====
module nnt_search #(
  parameter int MAX_DETECTIONS = 16,
  parameter int COORD_BITS     = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nnt_pkg::nnt_ctl_t     ctl,
  input  logic [COORD_BITS-1:0] det_x,
  input  logic [COORD_BITS-1:0] det_y,
  input  logic [COORD_BITS-1:0] ref_x,
  input  logic [COORD_BITS-1:0] ref_y,
  output logic                  sel_any,
  output logic [COORD_BITS-1:0] sel_x,
  output logic [COORD_BITS-1:0] sel_y
);

  localparam int SEEN_W = $clog2(MAX_DETECTIONS + 1);
  localparam int DIST_W = COORD_BITS + 1;

  logic [SEEN_W-1:0]     seen_r, seen_nxt;
  logic [DIST_W-1:0]     best_dist_r, best_dist_nxt;
  logic [COORD_BITS-1:0] best_x_r, best_x_nxt;
  logic [COORD_BITS-1:0] best_y_r, best_y_nxt;

  logic [COORD_BITS-1:0] dx, dy;
  logic [DIST_W-1:0]     cand_dist;
  logic                  room, take_ok, closer, upd;

  // manhattan distance to the reference point
  always_comb begin
    dx        = (det_x >= ref_x) ? (det_x - ref_x) : (ref_x - det_x);
    dy        = (det_y >= ref_y) ? (det_y - ref_y) : (ref_y - det_y);
    cand_dist = {1'b0, dx} + {1'b0, dy};
  end

  // running minimum, earliest detection kept on ties
  always_comb begin
    room    = seen_r < SEEN_W'(MAX_DETECTIONS);
    take_ok = ctl.take && room;
    closer  = (seen_r == '0) || (cand_dist < best_dist_r);
    upd     = take_ok && closer;

    sel_any = (seen_r != '0) || take_ok;
    sel_x   = upd ? det_x : best_x_r;
    sel_y   = upd ? det_y : best_y_r;

    seen_nxt      = seen_r;
    best_dist_nxt = best_dist_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    if (ctl.fin) begin
      seen_nxt = '0;
    end else if (take_ok) begin
      seen_nxt = seen_r + 1'b1;
      if (closer) begin
        best_dist_nxt = cand_dist;
        best_x_nxt    = det_x;
        best_y_nxt    = det_y;
      end
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_dist_r <= best_dist_nxt;
    best_x_r    <= best_x_nxt;
    best_y_r    <= best_y_nxt;
  end

endmodule

// ===== hw/rtl/nnt_gate.sv =====
module nnt_gate #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nnt_pkg::nnt_ctl_t              ctl,
  input  logic [nnt_pkg::CFG_W-1:0]      center_x,
  input  logic [nnt_pkg::CFG_W-1:0]      center_y,
  input  logic [nnt_pkg::CFG_W-1:0]      max_jump_x,
  input  logic [nnt_pkg::CFG_W-1:0]      max_jump_y,
  input  logic [nnt_pkg::LOST_W-1:0]     max_lost,
  input  logic                           sel_any,
  input  logic [COORD_BITS-1:0]          sel_x,
  input  logic [COORD_BITS-1:0]          sel_y,
  output logic [COORD_BITS-1:0]          ref_x,
  output logic [COORD_BITS-1:0]          ref_y,
  output logic                           res_locked,
  output logic                           res_visible,
  output logic signed [COORD_BITS:0]     res_err_x,
  output logic signed [COORD_BITS:0]     res_err_y,
  output logic signed [COORD_BITS:0]     res_jump_x,
  output logic signed [COORD_BITS:0]     res_jump_y,
  output logic                           res_jump_ok_x,
  output logic                           res_jump_ok_y,
  output logic [nnt_pkg::LOST_W-1:0]     res_lost,
  output logic [COORD_BITS-1:0]          res_pick_x,
  output logic [COORD_BITS-1:0]          res_pick_y
);

  localparam int MW = (COORD_BITS > nnt_pkg::CFG_W) ? COORD_BITS : nnt_pkg::CFG_W;
  localparam int EW = MW + 1;

  // tracker state
  logic [COORD_BITS-1:0]      last_x_r, last_x_nxt;
  logic [COORD_BITS-1:0]      last_y_r, last_y_nxt;
  logic                       have_last_r, have_last_nxt;
  logic                       lock_r, lock_nxt;
  logic [nnt_pkg::LOST_W-1:0] lost_r, lost_nxt;
  logic signed [COORD_BITS:0] err_x_r, err_x_nxt;
  logic signed [COORD_BITS:0] err_y_r, err_y_nxt;
  logic signed [COORD_BITS:0] jump_x_r, jump_x_nxt;
  logic signed [COORD_BITS:0] jump_y_r, jump_y_nxt;
  logic                       vis_r, vis_nxt;
  logic                       okx_r, okx_nxt;
  logic                       oky_r, oky_nxt;

  logic [MW-1:0]              cx_w, cy_w, sx_w, sy_w;
  logic signed [EW-1:0]       ex_w, ey_w;
  logic signed [COORD_BITS:0] jx, jy, jx_neg, jy_neg;
  logic [COORD_BITS-1:0]      magx, magy;
  logic                       okx, oky;
  logic [nnt_pkg::LOST_W-1:0] lost_inc;

  // reference point for the search
  always_comb begin
    cx_w  = MW'(center_x);
    cy_w  = MW'(center_y);
    ref_x = have_last_r ? last_x_r : cx_w[COORD_BITS-1:0];
    ref_y = have_last_r ? last_y_r : cy_w[COORD_BITS-1:0];
  end

  // error from center, move from last position, per-axis gate
  always_comb begin
    sx_w   = MW'(sel_x);
    sy_w   = MW'(sel_y);
    ex_w   = $signed({1'b0, sx_w}) - $signed({1'b0, cx_w});
    ey_w   = $signed({1'b0, cy_w}) - $signed({1'b0, sy_w});
    jx     = $signed({1'b0, sel_x}) - $signed({1'b0, last_x_r});
    jy     = $signed({1'b0, sel_y}) - $signed({1'b0, last_y_r});
    jx_neg = -jx;
    jy_neg = -jy;
    magx   = jx[COORD_BITS] ? jx_neg[COORD_BITS-1:0] : jx[COORD_BITS-1:0];
    magy   = jy[COORD_BITS] ? jy_neg[COORD_BITS-1:0] : jy[COORD_BITS-1:0];
    okx    = MW'(magx) <= MW'(max_jump_x);
    oky    = MW'(magy) <= MW'(max_jump_y);
    lost_inc = (lost_r != nnt_pkg::LOST_SAT) ? lost_r + 1'b1 : lost_r;
  end

  // frame end decision
  always_comb begin
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    have_last_nxt = have_last_r;
    lock_nxt      = lock_r;
    lost_nxt      = lost_r;
    err_x_nxt     = err_x_r;
    err_y_nxt     = err_y_r;
    jump_x_nxt    = jump_x_r;
    jump_y_nxt    = jump_y_r;
    vis_nxt       = vis_r;
    okx_nxt       = okx_r;
    oky_nxt       = oky_r;

    if (sel_any && (!lock_r || (okx && oky))) begin
      // accept the pick
      if (!lock_r) begin
        jump_x_nxt = '0;
        jump_y_nxt = '0;
        okx_nxt    = 1'b1;
        oky_nxt    = 1'b1;
      end else begin
        jump_x_nxt = jx;
        jump_y_nxt = jy;
        okx_nxt    = 1'b1;
        oky_nxt    = 1'b1;
      end
      last_x_nxt    = sel_x;
      last_y_nxt    = sel_y;
      have_last_nxt = 1'b1;
      err_x_nxt     = $signed(ex_w[COORD_BITS:0]);
      err_y_nxt     = $signed(ey_w[COORD_BITS:0]);
      lost_nxt      = '0;
      lock_nxt      = 1'b1;
      vis_nxt       = 1'b1;
    end else begin
      // empty frame or rejected pick counts a lost frame
      if (sel_any) begin
        jump_x_nxt = jx;
        jump_y_nxt = jy;
        okx_nxt    = okx;
        oky_nxt    = oky;
      end
      lost_nxt = lost_inc;
      vis_nxt  = 1'b0;
      if (lost_inc > max_lost) begin
        lock_nxt   = 1'b0;
        err_x_nxt  = '0;
        err_y_nxt  = '0;
        jump_x_nxt = '0;
        jump_y_nxt = '0;
        okx_nxt    = 1'b0;
        oky_nxt    = 1'b0;
      end
    end
  end

  // result fields follow the state after this frame
  always_comb begin
    res_locked    = lock_nxt;
    res_visible   = vis_nxt;
    res_err_x     = err_x_nxt;
    res_err_y     = err_y_nxt;
    res_jump_x    = jump_x_nxt;
    res_jump_y    = jump_y_nxt;
    res_jump_ok_x = okx_nxt;
    res_jump_ok_y = oky_nxt;
    res_lost      = lost_nxt;
    res_pick_x    = sel_any ? sel_x : '0;
    res_pick_y    = sel_any ? sel_y : '0;
  end

  // state update at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      have_last_r <= 1'b0;
      lock_r      <= 1'b0;
      lost_r      <= '0;
      err_x_r     <= '0;
      err_y_r     <= '0;
      jump_x_r    <= '0;
      jump_y_r    <= '0;
      vis_r       <= 1'b0;
      okx_r       <= 1'b0;
      oky_r       <= 1'b0;
    end else if (ctl.fin) begin
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      have_last_r <= have_last_nxt;
      lock_r      <= lock_nxt;
      lost_r      <= lost_nxt;
      err_x_r     <= err_x_nxt;
      err_y_r     <= err_y_nxt;
      jump_x_r    <= jump_x_nxt;
      jump_y_r    <= jump_y_nxt;
      vis_r       <= vis_nxt;
      okx_r       <= okx_nxt;
      oky_r       <= oky_nxt;
    end
  end

  // a lock always has a position to track from
  a_lock_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r |-> have_last_r)
    else $error("locked without a last position");

  // errors are cleared whenever the lock is not held
  a_unlocked_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !lock_r |-> (err_x_r == '0 && err_y_r == '0))
    else $error("nonzero error while unlocked");

  // a visible target resets the lost count
  a_visible_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    vis_r |-> (lost_r == '0 && lock_r))
    else $error("visible target with lost frames pending");

endmodule

// ===== hw/rtl/nearest_target_tracker.sv =====
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall | in_cmd, in_det_x, in_det_y
// out_    | output    | out_valid/out_stall | locked, visible, err, jump, flags, lost, pick
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; a frame-end item's result is registered as the
// item leaves the input register, which sets the rate by feeding search and gate in one pass
// rst_n is synchronous: tracker unlocked, no last position, control and config registers cleared
// out_stall holds the result register; the input register then holds a frame-end item
// cfg_ready is always high; user rule, not enforced: writes go in while no item is in flight
module nearest_target_tracker #(
  parameter int MAX_DETECTIONS = 16,
  parameter int COORD_BITS     = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic [COORD_BITS-1:0]             in_det_x,
  input  logic [COORD_BITS-1:0]             in_det_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_locked,
  output logic                              out_visible,
  output logic signed [COORD_BITS:0]        out_err_x,
  output logic signed [COORD_BITS:0]        out_err_y,
  output logic signed [COORD_BITS:0]        out_jump_x,
  output logic signed [COORD_BITS:0]        out_jump_y,
  output logic                              out_jump_ok_x,
  output logic                              out_jump_ok_y,
  output logic [nnt_pkg::LOST_W-1:0]        out_lost_frames,
  output logic [COORD_BITS-1:0]             out_pick_x,
  output logic [COORD_BITS-1:0]             out_pick_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnt_pkg::CFG_W-1:0]         cfg_data
);

  // configuration registers
  logic [nnt_pkg::CFG_W-1:0]  center_x_r, center_y_r, max_jump_x_r, max_jump_y_r;
  logic [nnt_pkg::LOST_W-1:0] max_lost_r;

  // input register
  logic                  in_vld_r;
  logic [1:0]            in_cmd_r;
  logic [COORD_BITS-1:0] in_x_r, in_y_r;

  // result register
  logic                           out_vld_r;
  logic                           o_locked_r, o_visible_r, o_okx_r, o_oky_r;
  logic signed [COORD_BITS:0]     o_err_x_r, o_err_y_r, o_jump_x_r, o_jump_y_r;
  logic [nnt_pkg::LOST_W-1:0]     o_lost_r;
  logic [COORD_BITS-1:0]          o_pick_x_r, o_pick_y_r;

  logic                  is_take, is_fin, out_free, go, in_acc;
  nnt_pkg::nnt_ctl_t     ctl;

  logic                       sel_any;
  logic [COORD_BITS-1:0]      sel_x, sel_y, ref_x, ref_y;
  logic                       r_locked, r_visible, r_okx, r_oky;
  logic signed [COORD_BITS:0] r_err_x, r_err_y, r_jump_x, r_jump_y;
  logic [nnt_pkg::LOST_W-1:0] r_lost;
  logic [COORD_BITS-1:0]      r_pick_x, r_pick_y;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      max_jump_x_r <= '0;
      max_jump_y_r <= '0;
      max_lost_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nnt_pkg::REG_CENTER_X:   center_x_r   <= cfg_data;
        nnt_pkg::REG_CENTER_Y:   center_y_r   <= cfg_data;
        nnt_pkg::REG_MAX_JUMP_X: max_jump_x_r <= cfg_data;
        nnt_pkg::REG_MAX_JUMP_Y: max_jump_y_r <= cfg_data;
        nnt_pkg::REG_MAX_LOST:   max_lost_r   <= cfg_data[nnt_pkg::LOST_W-1:0];
        default: ;
      endcase
    end
  end

  // item decode
  always_comb begin
    unique case (in_cmd_r)
      nnt_pkg::CMD_DET:     begin is_take = 1'b1; is_fin = 1'b0; end
      nnt_pkg::CMD_DET_END: begin is_take = 1'b1; is_fin = 1'b1; end
      nnt_pkg::CMD_END:     begin is_take = 1'b0; is_fin = 1'b1; end
      default:              begin is_take = 1'b0; is_fin = 1'b0; end
    endcase
  end

  // flow control: an item without a result never waits
  always_comb begin
    out_free = !out_vld_r || !out_stall;
    go       = in_vld_r && (!is_fin || out_free);
    in_stall = in_vld_r && !go;
    in_acc   = in_valid && !in_stall;
    ctl.take = go && is_take;
    ctl.fin  = go && is_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cmd_r <= in_cmd;
      in_x_r   <= in_det_x;
      in_y_r   <= in_det_y;
    end
  end

  nnt_search #(
    .MAX_DETECTIONS (MAX_DETECTIONS),
    .COORD_BITS     (COORD_BITS)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .det_x   (in_x_r),
    .det_y   (in_y_r),
    .ref_x   (ref_x),
    .ref_y   (ref_y),
    .sel_any (sel_any),
    .sel_x   (sel_x),
    .sel_y   (sel_y)
  );

  nnt_gate #(
    .COORD_BITS (COORD_BITS)
  ) u_gate (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .center_x      (center_x_r),
    .center_y      (center_y_r),
    .max_jump_x    (max_jump_x_r),
    .max_jump_y    (max_jump_y_r),
    .max_lost      (max_lost_r),
    .sel_any       (sel_any),
    .sel_x         (sel_x),
    .sel_y         (sel_y),
    .ref_x         (ref_x),
    .ref_y         (ref_y),
    .res_locked    (r_locked),
    .res_visible   (r_visible),
    .res_err_x     (r_err_x),
    .res_err_y     (r_err_y),
    .res_jump_x    (r_jump_x),
    .res_jump_y    (r_jump_y),
    .res_jump_ok_x (r_okx),
    .res_jump_ok_y (r_oky),
    .res_lost      (r_lost),
    .res_pick_x    (r_pick_x),
    .res_pick_y    (r_pick_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.fin) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      o_locked_r  <= r_locked;
      o_visible_r <= r_visible;
      o_err_x_r   <= r_err_x;
      o_err_y_r   <= r_err_y;
      o_jump_x_r  <= r_jump_x;
      o_jump_y_r  <= r_jump_y;
      o_okx_r     <= r_okx;
      o_oky_r     <= r_oky;
      o_lost_r    <= r_lost;
      o_pick_x_r  <= r_pick_x;
      o_pick_y_r  <= r_pick_y;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_locked      = o_locked_r;
  assign out_visible     = o_visible_r;
  assign out_err_x       = o_err_x_r;
  assign out_err_y       = o_err_y_r;
  assign out_jump_x      = o_jump_x_r;
  assign out_jump_y      = o_jump_y_r;
  assign out_jump_ok_x   = o_okx_r;
  assign out_jump_ok_y   = o_oky_r;
  assign out_lost_frames = o_lost_r;
  assign out_pick_x      = o_pick_x_r;
  assign out_pick_y      = o_pick_y_r;

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int MAX_DET     = 16;
  localparam int COORD_W     = 12;
  localparam int NO_DIST     = 1 << 14;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYC  = 6;

  // one detection stream item
  typedef struct {
    nnt_pkg::nnt_cmd_t  cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } det_item_t;

  // one frame-end report
  typedef struct {
    logic                           locked;
    logic                           visible;
    logic signed [COORD_W:0]        err_x;
    logic signed [COORD_W:0]        err_y;
    logic signed [COORD_W:0]        jump_x;
    logic signed [COORD_W:0]        jump_y;
    logic                           ok_x;
    logic                           ok_y;
    logic [nnt_pkg::LOST_W-1:0]     lost;
    logic [COORD_W-1:0]             pick_x;
    logic [COORD_W-1:0]             pick_y;
  } track_report_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_cmd = '0;
  logic [COORD_W-1:0]            in_det_x = '0;
  logic [COORD_W-1:0]            in_det_y = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_locked;
  logic                          out_visible;
  logic signed [COORD_W:0]       out_err_x;
  logic signed [COORD_W:0]       out_err_y;
  logic signed [COORD_W:0]       out_jump_x;
  logic signed [COORD_W:0]       out_jump_y;
  logic                          out_jump_ok_x;
  logic                          out_jump_ok_y;
  logic [nnt_pkg::LOST_W-1:0]    out_lost_frames;
  logic [COORD_W-1:0]            out_pick_x;
  logic [COORD_W-1:0]            out_pick_y;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [nnt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nnt_pkg::CFG_W-1:0]     cfg_data = '0;

  nearest_target_tracker #(
    .MAX_DETECTIONS(MAX_DET),
    .COORD_BITS    (COORD_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_det_x       (in_det_x),
    .in_det_y       (in_det_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_locked     (out_locked),
    .out_visible    (out_visible),
    .out_err_x      (out_err_x),
    .out_err_y      (out_err_y),
    .out_jump_x     (out_jump_x),
    .out_jump_y     (out_jump_y),
    .out_jump_ok_x  (out_jump_ok_x),
    .out_jump_ok_y  (out_jump_ok_y),
    .out_lost_frames(out_lost_frames),
    .out_pick_x     (out_pick_x),
    .out_pick_y     (out_pick_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int cycle_count = 0;
  int mismatches  = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  det_item_t     detection_feed[$];
  track_report_t expected_reports[$];

  // tracker copy: configuration
  logic [COORD_W-1:0]         ctr_x = '0, ctr_y = '0;
  logic [COORD_W-1:0]         jump_lim_x = '0, jump_lim_y = '0;
  logic [nnt_pkg::LOST_W-1:0] lost_lim = '0;

  // tracker copy: track state
  logic [COORD_W-1:0]         trk_last_x = '0, trk_last_y = '0;
  bit                         trk_have_last = 1'b0;
  bit                         trk_lock = 1'b0;
  logic [nnt_pkg::LOST_W-1:0] trk_lost = '0;

  // tracker copy: running nearest search
  logic [COORD_W-1:0] best_x = '0, best_y = '0;
  int                 best_dist = NO_DIST;
  int                 seen_count = 0;

  // tracker copy: held report values
  logic signed [COORD_W:0] held_err_x = '0, held_err_y = '0;
  logic signed [COORD_W:0] held_jump_x = '0, held_jump_y = '0;
  bit                      held_visible = 1'b0, held_ok_x = 1'b0, held_ok_y = 1'b0;

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[COORD_W-1:0];
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // frame lost: bump the saturating count, drop the lock past the limit
  task automatic lose_frame();
    if (trk_lost != nnt_pkg::LOST_SAT) trk_lost = trk_lost + 1'b1;
    held_visible = 1'b0;
    if (trk_lost > lost_lim) begin
      trk_lock     = 1'b0;
      held_err_x   = '0;
      held_err_y   = '0;
      held_jump_x  = '0;
      held_jump_y  = '0;
      held_visible = 1'b0;
      held_ok_x    = 1'b0;
      held_ok_y    = 1'b0;
    end
  endtask

  task automatic lock_on_pick();
    trk_last_x    = best_x;
    trk_last_y    = best_y;
    trk_have_last = 1'b1;
    held_err_x    = (COORD_W+1)'(int'(best_x) - int'(ctr_x));
    held_err_y    = (COORD_W+1)'(int'(ctr_y) - int'(best_y));
    trk_lost      = '0;
    trk_lock      = 1'b1;
    held_visible  = 1'b1;
  endtask

  // predicted behavior of one accepted item
  task automatic track_item(logic [1:0] cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int            ref_x, ref_y, cand_dist, jx, jy;
    bit            any;
    track_report_t rpt;
    if (cmd == nnt_pkg::CMD_NONE) return;
    // nearest search over the first detections of the frame
    if (cmd != nnt_pkg::CMD_END && seen_count < MAX_DET) begin
      ref_x = trk_have_last ? int'(trk_last_x) : int'(ctr_x);
      ref_y = trk_have_last ? int'(trk_last_y) : int'(ctr_y);
      seen_count++;
      cand_dist = mag(int'(x) - ref_x) + mag(int'(y) - ref_y);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best_x    = x;
        best_y    = y;
      end
    end
    if (cmd == nnt_pkg::CMD_DET) return;
    // frame end
    any = (seen_count > 0);
    if (!any) begin
      lose_frame();
    end else if (!trk_lock) begin
      held_jump_x = '0;
      held_jump_y = '0;
      held_ok_x   = 1'b1;
      held_ok_y   = 1'b1;
      lock_on_pick();
    end else begin
      jx = int'(best_x) - int'(trk_last_x);
      jy = int'(best_y) - int'(trk_last_y);
      held_jump_x  = (COORD_W+1)'(jx);
      held_jump_y  = (COORD_W+1)'(jy);
      held_ok_x    = (mag(jx) <= int'(jump_lim_x));
      held_ok_y    = (mag(jy) <= int'(jump_lim_y));
      held_visible = 1'b0;
      if (held_ok_x && held_ok_y) lock_on_pick();
      else lose_frame();
    end
    rpt.locked  = trk_lock;
    rpt.visible = held_visible;
    rpt.err_x   = held_err_x;
    rpt.err_y   = held_err_y;
    rpt.jump_x  = held_jump_x;
    rpt.jump_y  = held_jump_y;
    rpt.ok_x    = held_ok_x;
    rpt.ok_y    = held_ok_y;
    rpt.lost    = trk_lost;
    rpt.pick_x  = any ? best_x : '0;
    rpt.pick_y  = any ? best_y : '0;
    expected_reports.push_back(rpt);
    seen_count = 0;
    best_dist  = NO_DIST;
    best_x     = '0;
    best_y     = '0;
  endtask

  // sender: bursts of items with random gaps
  int        burst_left = 8;
  int        gap_left   = 0;
  det_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_item(in_cmd, in_det_x, in_det_y);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (detection_feed.size() > 0) begin
          next_item = detection_feed.pop_front();
          in_valid <= 1'b1;
          in_cmd   <= next_item.cmd;
          in_det_x <= next_item.x;
          in_det_y <= next_item.y;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 9) == 0) begin
            // long stretch with no gaps
            burst_left = 200;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // receiver: compare reports and stall on a changing pattern
  int            stall_mode = 0;
  int            stall_hold = 0;
  track_report_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("report with no frame end pending");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("locked", want.locked, out_locked);
          check_field("visible", want.visible, out_visible);
          check_field("err_x", want.err_x, out_err_x);
          check_field("err_y", want.err_y, out_err_y);
          check_field("jump_x", want.jump_x, out_jump_x);
          check_field("jump_y", want.jump_y, out_jump_y);
          check_field("jump_ok_x", want.ok_x, out_jump_ok_x);
          check_field("jump_ok_y", want.ok_y, out_jump_ok_y);
          check_field("lost_frames", want.lost, out_lost_frames);
          check_field("pick_x", want.pick_x, out_pick_x);
          check_field("pick_y", want.pick_y, out_pick_y);
        end
      end
      if (stall_hold == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_hold = $urandom_range(64, 256);
      end else begin
        stall_hold--;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= (cycle_count[1:0] != 2'd0);
        end
      endcase
    end
  end

  // register write, called right after the clock rises
  task automatic write_reg(nnt_pkg::nnt_reg_t idx, logic [nnt_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nnt_pkg::REG_CENTER_X:   ctr_x = val;
      nnt_pkg::REG_CENTER_Y:   ctr_y = val;
      nnt_pkg::REG_MAX_JUMP_X: jump_lim_x = val;
      nnt_pkg::REG_MAX_JUMP_Y: jump_lim_y = val;
      nnt_pkg::REG_MAX_LOST:   lost_lim = val[nnt_pkg::LOST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int cx, int cy, int jx, int jy, int lost);
    write_reg(nnt_pkg::REG_CENTER_X, nnt_pkg::CFG_W'(cx));
    write_reg(nnt_pkg::REG_CENTER_Y, nnt_pkg::CFG_W'(cy));
    write_reg(nnt_pkg::REG_MAX_JUMP_X, nnt_pkg::CFG_W'(jx));
    write_reg(nnt_pkg::REG_MAX_JUMP_Y, nnt_pkg::CFG_W'(jy));
    write_reg(nnt_pkg::REG_MAX_LOST, nnt_pkg::CFG_W'(lost));
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(nnt_pkg::nnt_cmd_t cmd, int x, int y);
    det_item_t it;
    it.cmd = cmd;
    it.x   = x[COORD_W-1:0];
    it.y   = y[COORD_W-1:0];
    detection_feed.push_back(it);
  endtask

  // wait until every item is in and every report is out, then let the pipe drain
  task automatic settle();
    do @(posedge clk);
    while (detection_feed.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // frames around a drifting target, with clutter and the odd broken frame
  int tgt_x = 2048, tgt_y = 2048;

  task automatic run_frames(int n_frames, int span);
    int                n, hit, r;
    bit                split_end;
    nnt_pkg::nnt_cmd_t cmd;
    int                dx, dy;
    for (int f = 0; f < n_frames; f++) begin
      r = $urandom_range(0, 99);
      if (r < 8) n = 0;
      else if (r < 16) n = $urandom_range(MAX_DET + 1, MAX_DET + 8);
      else n = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        tgt_x = $urandom_range(0, 4095);
        tgt_y = $urandom_range(0, 4095);
      end else begin
        tgt_x = clamp_coord(tgt_x + jitter(span));
        tgt_y = clamp_coord(tgt_y + jitter(span));
      end
      hit = -1;
      if (n > 0 && $urandom_range(0, 99) < 85) hit = $urandom_range(0, n - 1);
      split_end = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (i == hit) begin
          dx = clamp_coord(tgt_x + jitter(2));
          dy = clamp_coord(tgt_y + jitter(2));
        end else if (r < 70) begin
          dx = $urandom_range(0, 4095);
          dy = $urandom_range(0, 4095);
        end else if (r < 85) begin
          dx = $urandom_range(0, 1) ? 4095 : 0;
          dy = $urandom_range(0, 1) ? 4095 : 0;
        end else begin
          dx = clamp_coord(tgt_x + jitter(2 * span + 1));
          dy = clamp_coord(tgt_y + jitter(2 * span + 1));
        end
        cmd = (i == n - 1 && !split_end) ? nnt_pkg::CMD_DET_END : nnt_pkg::CMD_DET;
        push_item(cmd, dx, dy);
        if ($urandom_range(0, 32) == 0)
          push_item(nnt_pkg::CMD_NONE, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      if (n == 0 || split_end)
        push_item(nnt_pkg::CMD_END, $urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under reset registers: center at origin, zero jump, zero lost
    push_item(nnt_pkg::CMD_NONE, 4095, 4095);
    push_item(nnt_pkg::CMD_END, 4095, 4095);      // empty frame while unlocked
    push_item(nnt_pkg::CMD_DET, 100, 0);
    push_item(nnt_pkg::CMD_DET, 0, 100);          // equal distance, earlier one stays
    push_item(nnt_pkg::CMD_NONE, 0, 0);           // ignored inside a frame
    push_item(nnt_pkg::CMD_DET, 4095, 4095);
    push_item(nnt_pkg::CMD_DET_END, 50, 51);      // first lock
    push_item(nnt_pkg::CMD_DET_END, 100, 0);      // zero move passes
    push_item(nnt_pkg::CMD_DET_END, 101, 0);      // rejected move drops the lock
    push_item(nnt_pkg::CMD_DET, 0, 0);
    push_item(nnt_pkg::CMD_DET, 4095, 4095);
    push_item(nnt_pkg::CMD_END, 4095, 4095);      // frame end after detections
    push_item(nnt_pkg::CMD_DET_END, 4095, 4095);
    push_item(nnt_pkg::CMD_DET_END, 4095, 0);
    push_item(nnt_pkg::CMD_DET_END, 0, 4095);
    push_item(nnt_pkg::CMD_DET_END, 0, 4095);
    push_item(nnt_pkg::CMD_END, 0, 0);            // empty frame while locked
    push_item(nnt_pkg::CMD_DET_END, 2730, 1365);
    settle();

    // tracking with moderate gates
    set_config(2048, 1536, 64, 64, 3);
    tgt_x = 2048;
    tgt_y = 1536;
    run_frames(70, 70);
    settle();

    // wide gates and a lost limit that never drops the lock
    set_config(4095, 4095, 4095, 4095, 255);
    run_frames(20, 500);
    push_item(nnt_pkg::CMD_DET_END, 0, 0);
    push_item(nnt_pkg::CMD_DET_END, 4095, 4095);
    push_item(nnt_pkg::CMD_DET_END, 0, 0);
    for (int i = 0; i < 300; i++)
      push_item(nnt_pkg::CMD_END, $urandom_range(0, 4095), $urandom_range(0, 4095));
    run_frames(10, 500);
    settle();

    // zero horizontal gate, no lost frames tolerated
    set_config(0, 4095, 0, 4095, 0);
    run_frames(50, 2);
    settle();

    // random centers and small gates
    set_config($urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 8));
    run_frames(60, 1 + int'(jump_lim_x > jump_lim_y ? jump_lim_x : jump_lim_y));
    settle();

    // random gates, longest lost limit that still drops
    set_config($urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095), 254);
    run_frames(60, 200);
    settle();

    if (expected_reports.size() != 0) begin
      $error("%0d frame reports never arrived", expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nnt_pkg.sv
hw/rtl/nnt_search.sv
hw/rtl/nnt_gate.sv
hw/rtl/nearest_target_tracker.sv
tb/tb.sv
